### hdl/sqvb_pkg.sv
// ----------------------------------------------------------------------------
// sqvb_pkg
// shared types, constants and the quarter-wave sine table for the quad batcher
// ----------------------------------------------------------------------------
package sqvb_pkg;

  // batch quad cap, applied to the quad limit register
  localparam int MAX_QUADS      = 16384;
  localparam int QUAD_CAP       = (MAX_QUADS < 16384) ? MAX_QUADS : 16384;
  localparam int QCOUNT_W       = 15;
  localparam int SCOUNT_W       = 6;
  localparam int SLOT_W         = 5;
  localparam int IDX_COUNT_W    = 17;
  localparam int CFG_DATA_W     = 15;

  // config register indexes
  localparam logic CFG_QUAD_LIMIT = 1'b0;
  localparam logic CFG_SLOT_LIMIT = 1'b1;

  // sine table: 1024 entries per turn, stored as one quarter plus the end point
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W       = 10;
  localparam int QTAB_LEN         = SINE_TABLE_DEPTH / 4 + 1;
  localparam int QTAB_SHIFT       = 32 - SINE_IDX_W;  // phase bits below the index
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210};

  localparam logic [15:0] FLAT_TILING = 16'd256;

  typedef logic [30:0] qtab_t [QTAB_LEN];

  // controller to datapath commands
  typedef struct packed {
    logic       cap;
    logic       hit;
    logic       decide;
    logic       batch_reset;
    logic       flush_load;
    logic       mul;
    logic       commit;
    logic       sum;
    logic       emit;
    logic [1:0] cnt;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_end;
    logic batch_empty;
    logic flush_needed;
    logic out_free;
  } dp_stat_t;

  // truncating q30 taylor series of sin over the first quarter turn
  function automatic qtab_t build_qtab();
    qtab_t             tab;
    longint unsigned   r;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    for (int j = 0; j < QTAB_LEN; j++) begin
      r    = longint'(j) << QTAB_SHIFT;
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 0; k < 7; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if ((k % 2) == 0) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
      tab[j] = 31'(sum);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // full-turn lookup by folding into the quarter table
  function automatic logic signed [31:0] sine_lookup(input logic [SINE_IDX_W-1:0] idx);
    logic [SINE_IDX_W-3:0] r;
    logic [SINE_IDX_W-2:0] j;
    logic signed [31:0]    mag;
    r = idx[SINE_IDX_W-3:0];
    if (idx[SINE_IDX_W-2]) j = (SINE_IDX_W-1)'(QTAB_LEN - 1) - {1'b0, r};
    else j = {1'b0, r};
    mag = signed'({1'b0, QTAB[j]});
    return idx[SINE_IDX_W-1] ? -mag : mag;
  endfunction

endpackage

### hdl/sqvb_datapath.sv
// ----------------------------------------------------------------------------
// sqvb_datapath
// batch counters, slot table, shared multiplier, corner sums and output word
// ----------------------------------------------------------------------------
module sqvb_datapath #(
  parameter int TEXTURE_SLOTS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [sqvb_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  func,
  input  logic signed [31:0]                    pos_x,
  input  logic signed [31:0]                    pos_y,
  input  logic signed [31:0]                    pos_z,
  input  logic signed [31:0]                    size_x,
  input  logic signed [31:0]                    size_y,
  input  logic [15:0]                           angle,
  input  logic [31:0]                           color,
  input  logic                                  textured,
  input  logic [15:0]                           texture_id,
  input  logic [15:0]                           tiling,
  input  sqvb_pkg::ctl_cmd_t                    cmd,
  output sqvb_pkg::dp_stat_t                    stat,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  kind,
  output logic signed [31:0]                    vert_x,
  output logic signed [31:0]                    vert_y,
  output logic signed [31:0]                    vert_z,
  output logic [31:0]                           vert_color,
  output logic                                  tex_u,
  output logic                                  tex_v,
  output logic [sqvb_pkg::SLOT_W-1:0]           slot,
  output logic [15:0]                           vert_tiling,
  output logic [sqvb_pkg::IDX_COUNT_W-1:0]      index_count,
  output logic [sqvb_pkg::SCOUNT_W-1:0]         slots_used,
  output logic                                  last
);

  localparam int SLOT_CAP  = (TEXTURE_SLOTS < 32) ? TEXTURE_SLOTS : 32;
  localparam int SLOT_AW   = $clog2(SLOT_CAP);

  logic [sqvb_pkg::CFG_DATA_W-1:0] quad_limit_reg;
  logic [sqvb_pkg::SCOUNT_W-1:0]   slot_limit_reg;
  logic [sqvb_pkg::QCOUNT_W-1:0]   qlim;
  logic [sqvb_pkg::SCOUNT_W-1:0]   slim;

  logic [sqvb_pkg::QCOUNT_W-1:0]   quad_count;
  logic [sqvb_pkg::SCOUNT_W-1:0]   slot_count;
  logic [15:0]                     slot_table [SLOT_CAP];

  logic                            c_end;
  logic signed [31:0]              c_px, c_py, c_pz, c_sx, c_sy;
  logic [31:0]                     c_color;
  logic                            c_tex;
  logic [15:0]                     c_tid;
  logic [15:0]                     c_tiling;
  logic signed [31:0]              sn, cs;

  logic [SLOT_CAP-1:0]             hit_vec;
  logic                            found;
  logic [sqvb_pkg::SLOT_W-1:0]     hit_slot;
  logic                            qfull;
  logic                            sfull;
  logic                            flush_needed;
  logic [sqvb_pkg::SLOT_W-1:0]     slot_sel;
  logic                            new_tex;

  logic signed [63:0]              prod [4];
  logic signed [31:0]              mul_a, mul_b;
  logic signed [63:0]              sum_x, sum_y;
  logic signed [32:0]              off_x, off_y;
  logic                            ex_pos, ey_pos;
  logic signed [33:0]              full_x, full_y;
  logic [sqvb_pkg::IDX_COUNT_W-1:0] qc_ext;

  // clamped limits
  always_comb begin
    if (quad_limit_reg == '0) qlim = sqvb_pkg::QCOUNT_W'(1);
    else if (quad_limit_reg > sqvb_pkg::CFG_DATA_W'(sqvb_pkg::QUAD_CAP))
      qlim = sqvb_pkg::QCOUNT_W'(sqvb_pkg::QUAD_CAP);
    else qlim = quad_limit_reg;
    if (slot_limit_reg < sqvb_pkg::SCOUNT_W'(2)) slim = sqvb_pkg::SCOUNT_W'(2);
    else if (slot_limit_reg > sqvb_pkg::SCOUNT_W'(SLOT_CAP))
      slim = sqvb_pkg::SCOUNT_W'(SLOT_CAP);
    else slim = slot_limit_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_limit_reg <= sqvb_pkg::CFG_DATA_W'(16384);
      slot_limit_reg <= sqvb_pkg::SCOUNT_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sqvb_pkg::CFG_QUAD_LIMIT: quad_limit_reg <= cfg_data;
        sqvb_pkg::CFG_SLOT_LIMIT: slot_limit_reg <= cfg_data[sqvb_pkg::SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture and sine/cosine fetch
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      c_end    <= func;
      c_px     <= pos_x;
      c_py     <= pos_y;
      c_pz     <= pos_z;
      c_sx     <= size_x;
      c_sy     <= size_y;
      c_color  <= color;
      c_tex    <= textured;
      c_tid    <= texture_id;
      c_tiling <= tiling;
      sn <= sqvb_pkg::sine_lookup(angle[15 -: sqvb_pkg::SINE_IDX_W]);
      cs <= sqvb_pkg::sine_lookup(angle[15 -: sqvb_pkg::SINE_IDX_W] +
                                  sqvb_pkg::SINE_IDX_W'(sqvb_pkg::SINE_TABLE_DEPTH / 4));
    end
  end

  // slot table match, registered
  always_ff @(posedge clk) begin
    if (cmd.hit) begin
      for (int i = 0; i < SLOT_CAP; i++) begin
        hit_vec[i] <= (i != 0) && (sqvb_pkg::SCOUNT_W'(i) < slot_count) &&
                      (slot_table[i] == c_tid);
      end
    end
  end

  always_comb begin
    found    = 1'b0;
    hit_slot = '0;
    for (int i = SLOT_CAP - 1; i >= 1; i--) begin
      if (hit_vec[i]) begin
        found    = 1'b1;
        hit_slot = sqvb_pkg::SLOT_W'(i);
      end
    end
  end

  assign qfull        = quad_count >= qlim;
  assign sfull        = slot_count >= slim;
  assign flush_needed = qfull || (c_tex && !found && sfull);

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (!c_tex) slot_sel <= '0;
      else if (flush_needed) slot_sel <= sqvb_pkg::SLOT_W'(1);
      else if (found) slot_sel <= hit_slot;
      else slot_sel <= slot_count[sqvb_pkg::SLOT_W-1:0];
      new_tex <= c_tex && (flush_needed || !found);
    end
  end

  // batch state
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_count <= '0;
      slot_count <= sqvb_pkg::SCOUNT_W'(1);
    end else if (cmd.flush_load || cmd.batch_reset) begin
      quad_count <= '0;
      slot_count <= sqvb_pkg::SCOUNT_W'(1);
    end else if (cmd.commit) begin
      quad_count <= quad_count + sqvb_pkg::QCOUNT_W'(1);
      if (new_tex) slot_count <= {1'b0, slot_sel} + sqvb_pkg::SCOUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && new_tex) slot_table[slot_sel[SLOT_AW-1:0]] <= c_tid;
  end

  // shared multiplier: sx*cos, sy*sin, sx*sin, sy*cos
  assign mul_a = cmd.cnt[0] ? c_sy : c_sx;
  assign mul_b = (cmd.cnt[0] ^ cmd.cnt[1]) ? sn : cs;

  always_ff @(posedge clk) begin
    if (cmd.mul) prod[cmd.cnt] <= mul_a * mul_b;
  end

  // corner offsets, rounded half up
  assign ex_pos = (cmd.cnt == 2'd1) || (cmd.cnt == 2'd2);
  assign ey_pos = cmd.cnt[1];

  always_comb begin
    sum_x = (ex_pos ? prod[0] : -prod[0]) - (ey_pos ? prod[1] : -prod[1]) +
            64'sd1073741824;
    sum_y = (ex_pos ? prod[2] : -prod[2]) + (ey_pos ? prod[3] : -prod[3]) +
            64'sd1073741824;
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      off_x <= sum_x[63:31];
      off_y <= sum_y[63:31];
    end
  end

  assign full_x = 34'(c_px) + 34'(off_x);
  assign full_y = 34'(c_py) + 34'(off_y);
  assign qc_ext = sqvb_pkg::IDX_COUNT_W'(quad_count);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    else if (v[33]) return 32'sh8000_0000;
    else return 32'sh7fff_ffff;
  endfunction

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.flush_load || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_load) begin
      kind        <= 1'b1;
      vert_x      <= '0;
      vert_y      <= '0;
      vert_z      <= '0;
      vert_color  <= '0;
      tex_u       <= 1'b0;
      tex_v       <= 1'b0;
      slot        <= '0;
      vert_tiling <= '0;
      index_count <= (qc_ext << 2) + (qc_ext << 1);
      slots_used  <= slot_count;
      last        <= c_end;
    end else if (cmd.emit) begin
      kind        <= 1'b0;
      vert_x      <= sat32(full_x);
      vert_y      <= sat32(full_y);
      vert_z      <= c_pz;
      vert_color  <= c_color;
      tex_u       <= ex_pos;
      tex_v       <= ey_pos;
      slot        <= slot_sel;
      vert_tiling <= c_tex ? c_tiling : sqvb_pkg::FLAT_TILING;
      index_count <= '0;
      slots_used  <= '0;
      last        <= (cmd.cnt == 2'd3);
    end
  end

  assign stat.is_end       = c_end;
  assign stat.batch_empty  = (quad_count == '0);
  assign stat.flush_needed = flush_needed;
  assign stat.out_free     = !out_valid || !out_stall;

endmodule

### hdl/sqvb_ctrl.sv
// ----------------------------------------------------------------------------
// sqvb_ctrl
// sequencer: match, decide, flush, multiply steps, then four corners
// ----------------------------------------------------------------------------
module sqvb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sqvb_pkg::dp_stat_t stat,
  output sqvb_pkg::ctl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_HIT    = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_FLUSH  = 7'b0001000,
    S_MUL    = 7'b0010000,
    S_SUM    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_HIT;
        end
      end
      S_HIT: begin
        cmd.hit    = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        cnt_next   = '0;
        if (stat.is_end) begin
          if (stat.batch_empty) begin
            cmd.batch_reset = 1'b1;
            state_next      = S_IDLE;
          end else begin
            state_next = S_FLUSH;
          end
        end else if (stat.flush_needed && !stat.batch_empty) begin
          state_next = S_FLUSH;
        end else begin
          // an empty batch still resets, without a word
          cmd.batch_reset = stat.flush_needed;
          state_next      = S_MUL;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush_load = 1'b1;
          state_next     = stat.is_end ? S_IDLE : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul  = 1'b1;
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd3) begin
          cmd.commit = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cnt_next   = cnt + 2'd1;
          state_next = (cnt == 2'd3) ? S_IDLE : S_SUM;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/sprite_quad_vertex_batcher.sv
// ----------------------------------------------------------------------------
// sprite_quad_vertex_batcher
// sprite quad to four-vertex expander with texture slot batching
// ----------------------------------------------------------------------------
// A draw word gives four vertex words (corners in order bottom-left,
// bottom-right, top-right, top-left), preceded by one flush word when the
// batch quad limit is reached or a textured quad needs a new slot in a full
// slot table. An end-scene word gives one flush word when the batch holds
// quads, otherwise nothing; either way the batch is reset. A draw word holds
// the input, plus any output stall, until its last vertex loads; an
// end-scene word holds it until its flush word loads or the batch resets.
// The sequencer steps through capture, a match of the texture id, the
// decision, an optional flush, four passes through the single 32x32
// multiplier, and per corner an offset sum, then translate and saturate into
// the output register. The last word of an item may wait in the output
// register while the next input word is taken.
module sprite_quad_vertex_batcher #(
  parameter int TEXTURE_SLOTS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // config writes
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [sqvb_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  func,
  input  logic signed [31:0]                    pos_x,
  input  logic signed [31:0]                    pos_y,
  input  logic signed [31:0]                    pos_z,
  input  logic signed [31:0]                    size_x,
  input  logic signed [31:0]                    size_y,
  input  logic [15:0]                           angle,
  input  logic [31:0]                           color,
  input  logic                                  textured,
  input  logic [15:0]                           texture_id,
  input  logic [15:0]                           tiling,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  kind,
  output logic signed [31:0]                    vert_x,
  output logic signed [31:0]                    vert_y,
  output logic signed [31:0]                    vert_z,
  output logic [31:0]                           vert_color,
  output logic                                  tex_u,
  output logic                                  tex_v,
  output logic [sqvb_pkg::SLOT_W-1:0]           slot,
  output logic [15:0]                           vert_tiling,
  output logic [sqvb_pkg::IDX_COUNT_W-1:0]      index_count,
  output logic [sqvb_pkg::SCOUNT_W-1:0]         slots_used,
  output logic                                  last
);

  // command and status between sequencer and datapath
  sqvb_pkg::ctl_cmd_t cmd;
  sqvb_pkg::dp_stat_t stat;

  sqvb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sqvb_datapath #(
    .TEXTURE_SLOTS (TEXTURE_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .size_x      (size_x),
    .size_y      (size_y),
    .angle       (angle),
    .color       (color),
    .textured    (textured),
    .texture_id  (texture_id),
    .tiling      (tiling),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .vert_x      (vert_x),
    .vert_y      (vert_y),
    .vert_z      (vert_z),
    .vert_color  (vert_color),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .slot        (slot),
    .vert_tiling (vert_tiling),
    .index_count (index_count),
    .slots_used  (slots_used),
    .last        (last)
  );

endmodule

### test/sprite_quad_vertex_batcher_tb.sv
// ----------------------------------------------------------------------------
// sprite_quad_vertex_batcher_tb
// self-checking bench for the sprite quad vertex batcher
// ----------------------------------------------------------------------------
// A queue of quad and end-scene words feeds a clocked driver. Every accepted
// word runs through a cycle-free copy of the batching and corner arithmetic,
// which appends the expected vertex and flush words. A clocked monitor pops
// one expectation per accepted output word and compares every field. The run
// walks through several limit settings, random gaps on both sides, one long
// receiver hold and a quiet final stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_quad_vertex_batcher_tb;

  localparam logic FUNC_DRAW  = 1'b0;
  localparam logic FUNC_END   = 1'b1;
  localparam logic KIND_VERT  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
  localparam int   SLOT_CAP   = 32;
  localparam int   HOLD_LEN   = 300;   // cycles of the long receiver hold
  localparam int   SETTLE     = 24;    // covers an end scene that gives nothing

  typedef struct {
    logic               fn;
    logic signed [31:0] px, py, pz, sx, sy;
    logic [15:0]        ang;
    logic [31:0]        col;
    logic               txd;
    logic [15:0]        tid, til;
  } quad_t;

  typedef struct {
    logic                             kind;
    logic [31:0]                      x, y, z, col;
    logic                             u, v;
    logic [sqvb_pkg::SLOT_W-1:0]      slot;
    logic [15:0]                      til;
    logic [sqvb_pkg::IDX_COUNT_W-1:0] idx;
    logic [sqvb_pkg::SCOUNT_W-1:0]    used;
    logic                             last;
  } vert_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [sqvb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, size_x = '0, size_y = '0;
  logic [15:0] angle = '0;
  logic [31:0] color = '0;
  logic textured = 1'b0;
  logic [15:0] texture_id = '0, tiling = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic signed [31:0] vert_x, vert_y, vert_z;
  logic [31:0] vert_color;
  logic tex_u, tex_v;
  logic [sqvb_pkg::SLOT_W-1:0] slot;
  logic [15:0] vert_tiling;
  logic [sqvb_pkg::IDX_COUNT_W-1:0] index_count;
  logic [sqvb_pkg::SCOUNT_W-1:0] slots_used;
  logic last;

  sprite_quad_vertex_batcher dut (.*);

  // ---- predictor state ----
  longint      sine_q30 [sqvb_pkg::SINE_TABLE_DEPTH];
  int          quad_lim_reg = 16384, slot_lim_reg = 32;
  int          quads_in_batch = 0, slots_bound = 1;
  logic [15:0] bound_ids [SLOT_CAP];

  quad_t pending_quads [$];
  vert_t expected_verts [$];
  int    errors = 0;

  // run controls, written only by the sequencing initial block
  bit calm = 1'b0;
  bit hold_arm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // flush word if the batch holds quads, then start a fresh batch
  task automatic close_batch(input logic lst);
    vert_t f;
    if (quads_in_batch != 0) begin
      f = '{default: '0};
      f.kind = KIND_FLUSH;
      f.idx  = sqvb_pkg::IDX_COUNT_W'(quads_in_batch * 6);
      f.used = sqvb_pkg::SCOUNT_W'(slots_bound);
      f.last = lst;
      expected_verts.push_back(f);
    end
    quads_in_batch = 0;
    slots_bound = 1;
  endtask

  // expected words for the word now on the input ports
  task automatic batch_quad();
    int qlim, slim, s;
    int unsigned si, ci;
    longint sn, cs, a, b, vx, vy;
    longint ex [4] = '{-1, 1, 1, -1};
    longint ey [4] = '{-1, -1, 1, 1};
    vert_t w;
    if (func == FUNC_END) begin
      close_batch(1'b1);
      return;
    end
    qlim = (quad_lim_reg < 1) ? 1 :
           (quad_lim_reg > sqvb_pkg::QUAD_CAP) ? sqvb_pkg::QUAD_CAP : quad_lim_reg;
    slim = (slot_lim_reg < 2) ? 2 : (slot_lim_reg > SLOT_CAP) ? SLOT_CAP : slot_lim_reg;
    if (quads_in_batch >= qlim) close_batch(1'b0);
    s = 0;
    if (textured) begin
      for (int i = 1; i < slots_bound; i++)
        if (s == 0 && bound_ids[i] == texture_id) s = i;
      if (s == 0) begin
        // table full: flush, then the new texture lands in slot one
        if (slots_bound >= slim) close_batch(1'b0);
        s = slots_bound;
        bound_ids[s] = texture_id;
        slots_bound++;
      end
    end
    si = angle >> 6;
    ci = 16'(angle + 16'd16384) >> 6;
    sn = sine_q30[si];
    cs = sine_q30[ci];
    for (int c = 0; c < 4; c++) begin
      a  = ex[c] * longint'(size_x);
      b  = ey[c] * longint'(size_y);
      // round half up, floor shift
      vx = (a * cs - b * sn + 64'sd1073741824) >>> 31;
      vy = (a * sn + b * cs + 64'sd1073741824) >>> 31;
      vx = vx + longint'(pos_x);
      vy = vy + longint'(pos_y);
      if (vx > 64'sd2147483647) vx = 64'sd2147483647;
      if (vx < -64'sd2147483648) vx = -64'sd2147483648;
      if (vy > 64'sd2147483647) vy = 64'sd2147483647;
      if (vy < -64'sd2147483648) vy = -64'sd2147483648;
      w = '{default: '0};
      w.kind = KIND_VERT;
      w.x    = 32'(vx);
      w.y    = 32'(vy);
      w.z    = pos_z;
      w.col  = color;
      w.u    = (c == 1 || c == 2);
      w.v    = (c >= 2);
      w.slot = sqvb_pkg::SLOT_W'(s);
      w.til  = textured ? tiling : sqvb_pkg::FLAT_TILING;
      w.last = (c == 3);
      expected_verts.push_back(w);
    end
    quads_in_batch++;
  endtask

  // ---- driver: one word per handshake, random gaps ----
  int send_gap = 0;
  always @(posedge clk) begin
    quad_t q;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) batch_quad();
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_quads.size() > 0) begin
          q = pending_quads.pop_front();
          func <= q.fn; pos_x <= q.px; pos_y <= q.py; pos_z <= q.pz;
          size_x <= q.sx; size_y <= q.sy; angle <= q.ang; color <= q.col;
          textured <= q.txd; texture_id <= q.tid; tiling <= q.til;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver stall: bursts plus one long hold ----
  int rx_gap = 0, hold_count = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= HOLD_LEN) hold_done = 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 6) == 0) begin
      rx_gap = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic bit field_ok(string nm, logic [63:0] e, logic [63:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, e, a);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---- monitor ----
  always @(posedge clk) begin
    vert_t e;
    bit ok;
    if (!rst && out_valid && !out_stall) begin
      if (expected_verts.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %b x %h y %h",
                 $time, kind, vert_x, vert_y);
        errors++;
      end else begin
        e = expected_verts.pop_front();
        ok = field_ok("kind", e.kind, kind);
        ok &= field_ok("vert_x", e.x, unsigned'(vert_x));
        ok &= field_ok("vert_y", e.y, unsigned'(vert_y));
        ok &= field_ok("vert_z", e.z, unsigned'(vert_z));
        ok &= field_ok("vert_color", e.col, vert_color);
        ok &= field_ok("tex_u", e.u, tex_u);
        ok &= field_ok("tex_v", e.v, tex_v);
        ok &= field_ok("slot", e.slot, slot);
        ok &= field_ok("vert_tiling", e.til, vert_tiling);
        ok &= field_ok("index_count", e.idx, index_count);
        ok &= field_ok("slots_used", e.used, slots_used);
        ok &= field_ok("last", e.last, last);
        if (!ok) errors++;
      end
    end
  end

  function automatic logic [31:0] edge_val();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // random quad; ids from a small pool so that slots get reused
  function automatic quad_t rand_quad(int pool, int end_pct);
    quad_t q;
    q.fn  = ($urandom_range(0, 99) < end_pct) ? FUNC_END : FUNC_DRAW;
    q.px  = edge_val();
    q.py  = edge_val();
    q.pz  = $urandom;
    // mostly moderate sizes, sometimes anything
    q.sx  = ($urandom_range(0, 3) == 0) ? edge_val() : 32'($urandom_range(0, 32'h00ff_ffff)) -
            32'h0080_0000;
    q.sy  = ($urandom_range(0, 3) == 0) ? edge_val() : 32'($urandom_range(0, 32'h00ff_ffff)) -
            32'h0080_0000;
    q.ang = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3) * 16384) : 16'($urandom);
    q.col = $urandom;
    q.txd = ($urandom_range(0, 9) < 7);
    q.tid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, pool - 1)) ^
            16'hff00;
    q.til = $urandom;
    return q;
  endfunction

  function automatic quad_t mk(logic fn, logic [31:0] px, py, sx, sy, logic [15:0] ang,
                               logic txd, logic [15:0] tid, til);
    quad_t q;
    q = '{fn, px, py, $urandom, sx, sy, ang, $urandom, txd, tid, til};
    return q;
  endfunction

  task automatic write_reg(input logic idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= sqvb_pkg::CFG_DATA_W'(val);
    if (idx == sqvb_pkg::CFG_QUAD_LIMIT) quad_lim_reg = val & 32'h7fff;
    else slot_lim_reg = val & 32'h3f;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender waits until every expected word is out, then lets the block settle
  task automatic drain();
    do @(negedge clk);
    while (pending_quads.size() != 0 || in_valid || expected_verts.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_random(int n, int pool, int end_pct);
    @(negedge clk);
    repeat (n) pending_quads.push_back(rand_quad(pool, end_pct));
  endtask

  // ---- sequencing ----
  initial begin
    longint unsigned r, x, x2, term;
    longint sum;
    int unsigned ph;
    // sine table, quarter-wave fold and truncating Taylor series
    for (int i = 0; i < sqvb_pkg::SINE_TABLE_DEPTH; i++) begin
      ph = i << 22;
      r  = ph & 32'h3fff_ffff;
      if (ph[30]) r = 64'd1073741824 - r;
      x  = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k & 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      sine_q30[i] = ph[31] ? -sum : sum;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset limits, angle quadrants, saturation, slot reuse, end scene
    @(negedge clk);
    pending_quads.push_back(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0));  // empty batch
    pending_quads.push_back(mk(FUNC_DRAW, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0));
    pending_quads.push_back(mk(FUNC_DRAW, 32'h50000, 32'hfffb0000, 32'h20000, 32'h30000,
                               16384, 1, 5, 512));
    pending_quads.push_back(mk(FUNC_DRAW, 0, 0, 32'h10000, 32'h20000, 32768, 1, 5, 16'hffff));
    pending_quads.push_back(mk(FUNC_DRAW, 0, 0, 32'h10000, 32'h20000, 49152, 1, 16'hffff, 0));
    pending_quads.push_back(mk(FUNC_DRAW, 0, 0, 32'h10000, 32'h20000, 65535, 1, 0, 256));
    pending_quads.push_back(mk(FUNC_DRAW, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 0, 0, 0, 0));
    pending_quads.push_back(mk(FUNC_DRAW, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 0, 1, 7, 1));
    pending_quads.push_back(mk(FUNC_DRAW, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                               32'h80000000, 8192, 1, 5, 3));
    pending_quads.push_back(mk(FUNC_DRAW, 32'hffffffff, 1, 32'hffffffff, 1, 1, 0, 16'hffff,
                               16'hffff));
    pending_quads.push_back(mk(FUNC_DRAW, 0, 0, 0, 0, 24576, 1, 16'haaaa, 16'h5555));
    pending_quads.push_back(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_quads.push_back(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_quads.push_back(mk(FUNC_DRAW, 32'h12345678, 32'h9abcdef0, 32'h00018000,
                               32'hffff8000, 40000, 1, 16'h5555, 16'haaaa));
    pending_quads.push_back(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // smallest limits, out-of-range slot limit clamps up to two
    write_reg(sqvb_pkg::CFG_QUAD_LIMIT, 1);
    write_reg(sqvb_pkg::CFG_SLOT_LIMIT, 0);
    push_random(60, 6, 5);
    drain();

    // small limits; the long receiver hold backs the block up into its input
    write_reg(sqvb_pkg::CFG_QUAD_LIMIT, 3);
    write_reg(sqvb_pkg::CFG_SLOT_LIMIT, 5);
    hold_arm = 1'b1;
    push_random(120, 12, 4);
    drain();

    // clamped maxima, a long batch with many textures and no end scene
    write_reg(sqvb_pkg::CFG_QUAD_LIMIT, 32767);
    write_reg(sqvb_pkg::CFG_SLOT_LIMIT, 63);
    push_random(45, 40, 0);
    drain();
    write_reg(sqvb_pkg::CFG_QUAD_LIMIT, 16384);
    write_reg(sqvb_pkg::CFG_SLOT_LIMIT, 32);
    push_random(45, 40, 0);
    drain();

    // limits lowered under a full batch: the next draw flushes at once
    write_reg(sqvb_pkg::CFG_QUAD_LIMIT, 2);
    write_reg(sqvb_pkg::CFG_SLOT_LIMIT, 3);
    push_random(70, 8, 5);
    drain();

    // quiet tail: no idling on either side
    write_reg(sqvb_pkg::CFG_QUAD_LIMIT, 7);
    write_reg(sqvb_pkg::CFG_SLOT_LIMIT, 4);
    calm = 1'b1;
    push_random(100, 10, 6);
    drain();

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
